// File: hw/rtl/grb_pkg.sv
// shared types and constants for the geometry residual binarizer
// no dependencies; imported by grb_front, grb_back and the top level
package grb_pkg;

   // input modes
   localparam logic [1:0] MODE_RUN  = 2'd0;
   localparam logic [1:0] MODE_RES  = 2'd1;
   localparam logic [1:0] MODE_TERM = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   // context kinds carried with each bin
   localparam logic [2:0] KIND_LEN_EQ0    = 3'd0;
   localparam logic [2:0] KIND_LEN_PREFIX = 3'd1;
   localparam logic [2:0] KIND_LEN_SUFFIX = 3'd2;
   localparam logic [2:0] KIND_RES_EQ0    = 3'd3;
   localparam logic [2:0] KIND_RES_SIGN   = 3'd4;
   localparam logic [2:0] KIND_RES_PREFIX = 3'd5;
   localparam logic [2:0] KIND_RES_SUFFIX = 3'd6;
   localparam logic [2:0] KIND_FINAL      = 3'd7;

   // bins per request, later ones are dropped
   localparam int MAX_BINS = 32;
   localparam int CNT_BITS = $clog2(MAX_BINS);

   // parameter defaults
   localparam int NUM_RES_CONTEXTS_DEF = 8;
   localparam int VALUE_BITS_DEF       = 16;

   // classified request, control part
   typedef struct packed {
      logic [1:0] mode;
      logic       zero;
      logic       neg;
      logic       flag;
      logic [2:0] ctx;
   } cmd_type;

endpackage

// File: hw/rtl/grb_front.sv
// front end: accepts requests, classifies them and queues them for the back end
// depends on grb_pkg
module grb_front
   import grb_pkg::*;
#(
   parameter int NUM_RES_CONTEXTS = NUM_RES_CONTEXTS_DEF,
   parameter int VALUE_BITS       = VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [1:0]                   req_mode,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic [2:0]                   req_ctx_select,
   output logic                         q_valid,
   input  logic                         q_pop,
   output cmd_type                      q_cmd,
   output logic [VALUE_BITS-1:0]        q_sym
);

   localparam int         CTX_MAX_INT = (NUM_RES_CONTEXTS > 8) ? 7 : NUM_RES_CONTEXTS - 1;
   localparam logic [2:0] CTX_MAX     = 3'(CTX_MAX_INT);

   // two-entry queue
   cmd_type               cmd_q_ff [2];
   logic [VALUE_BITS-1:0] sym_q_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;

   logic                  accept, write;
   logic [VALUE_BITS-1:0] raw, mag, len, base;
   logic                  neg;
   logic [2:0]            ctx;
   cmd_type               cmd_new;

   always_comb begin
      raw = VALUE_BITS'(req_value);
      neg = raw[VALUE_BITS-1];
      // most negative value maps onto its exact magnitude as unsigned
      mag = neg ? (~raw + VALUE_BITS'(1)) : raw;
      len = neg ? '0 : mag;
      ctx = (32'(req_ctx_select) >= NUM_RES_CONTEXTS) ? CTX_MAX : req_ctx_select;
      base = (req_mode == MODE_RUN) ? len : mag;
      cmd_new.mode = req_mode;
      cmd_new.zero = (base == '0);
      cmd_new.neg  = neg;
      cmd_new.flag = raw[0];
      cmd_new.ctx  = ctx;
   end

   assign req_full = (count_ff == 2'd2);
   assign accept   = req_push && !req_full;
   // unused mode yields no bins, so it is dropped here
   assign write    = accept && (req_mode != MODE_NONE);
   assign q_valid  = (count_ff != 2'd0);
   assign q_cmd    = cmd_q_ff[rd_ptr_ff];
   assign q_sym    = sym_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = write ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(write) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write) begin
         cmd_q_ff[wr_ptr_ff] <= cmd_new;
         sym_q_ff[wr_ptr_ff] <= base - VALUE_BITS'(1);
      end
   end

endmodule

// File: hw/rtl/grb_back.sv
// back end: walks one classified request bin by bin into the result register
// depends on grb_pkg
module grb_back
   import grb_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  cmd_type               q_cmd,
   input  logic [VALUE_BITS-1:0] q_sym,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_bin,
   output logic [2:0]            rsp_context_kind,
   output logic [2:0]            rsp_context_index,
   output logic                  rsp_last_bin,
   output logic                  rsp_flush
);

   localparam int KW = $clog2(VALUE_BITS + 1);

   typedef enum logic [1:0] {PH_HEAD, PH_SIGN, PH_PREFIX, PH_SUFFIX} phase_type;

   phase_type             phase_ff, phase_in;
   logic                  act_ff, act_in;
   cmd_type               cmd_ff;
   logic [VALUE_BITS-1:0] sym_ff, sym_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  rsp_valid_ff;
   logic                  bin_ff, last_ff, flush_ff;
   logic [2:0]            kind_ff, index_ff;

   logic                  out_ready, step, done;
   logic                  bin_in, nat_last, flush_in;
   logic [2:0]            kind_in, index_in;
   logic [VALUE_BITS:0]   pow_k;
   logic                  ge;
   logic [KW-1:0]         km1;
   logic [VALUE_BITS-1:0] shifted;

   assign out_ready = !rsp_valid_ff || rsp_pop;
   assign step      = act_ff && out_ready;
   assign q_pop     = !act_ff && q_valid;

   always_comb begin
      pow_k    = (VALUE_BITS + 1)'(1) << k_ff;
      ge       = {1'b0, sym_ff} >= pow_k;
      km1      = k_ff - KW'(1);
      shifted  = sym_ff >> km1;
      phase_in = phase_ff;
      sym_in   = sym_ff;
      k_in     = k_ff;
      bin_in   = 1'b0;
      nat_last = 1'b0;
      flush_in = 1'b0;
      kind_in  = KIND_FINAL;
      index_in = (cmd_ff.mode == MODE_RES) ? cmd_ff.ctx : 3'd0;
      unique case (phase_ff)
         PH_HEAD: begin
            if (cmd_ff.mode == MODE_TERM) begin
               bin_in   = cmd_ff.flag;
               kind_in  = KIND_FINAL;
               flush_in = 1'b1;
               nat_last = 1'b1;
            end else begin
               bin_in   = cmd_ff.zero;
               kind_in  = (cmd_ff.mode == MODE_RES) ? KIND_RES_EQ0 : KIND_LEN_EQ0;
               nat_last = cmd_ff.zero;
               if (cmd_ff.mode == MODE_RES) begin
                  phase_in = PH_SIGN;
               end else begin
                  phase_in = PH_PREFIX;
                  k_in     = KW'(2);
               end
            end
         end
         PH_SIGN: begin
            bin_in   = !cmd_ff.neg;
            kind_in  = KIND_RES_SIGN;
            phase_in = PH_PREFIX;
            k_in     = KW'(1);
         end
         PH_PREFIX: begin
            bin_in  = ge;
            kind_in = (cmd_ff.mode == MODE_RES) ? KIND_RES_PREFIX : KIND_LEN_PREFIX;
            if (ge) begin
               sym_in = sym_ff - pow_k[VALUE_BITS-1:0];
               k_in   = k_ff + KW'(1);
            end else begin
               phase_in = PH_SUFFIX;
            end
         end
         PH_SUFFIX: begin
            bin_in   = shifted[0];
            kind_in  = (cmd_ff.mode == MODE_RES) ? KIND_RES_SUFFIX : KIND_LEN_SUFFIX;
            k_in     = km1;
            nat_last = (k_ff == KW'(1));
         end
         default: begin
            phase_in = PH_HEAD;
         end
      endcase
      // the 32nd bin always closes the request
      done   = nat_last || (cnt_ff == CNT_BITS'(MAX_BINS - 1));
      cnt_in = cnt_ff + CNT_BITS'(1);
      act_in = act_ff;
      if (q_pop) begin
         act_in = 1'b1;
      end else if (step && done) begin
         act_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         phase_ff     <= PH_HEAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         if (q_pop) begin
            phase_ff <= PH_HEAD;
            cnt_ff   <= '0;
         end else if (step) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
         sym_ff <= q_sym;
         k_ff   <= '0;
      end else if (step) begin
         sym_ff <= sym_in;
         k_ff   <= k_in;
      end
      if (step) begin
         bin_ff   <= bin_in;
         kind_ff  <= kind_in;
         index_ff <= index_in;
         last_ff  <= done;
         flush_ff <= flush_in;
      end
   end

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_bin           = bin_ff;
   assign rsp_context_kind  = kind_ff;
   assign rsp_context_index = index_ff;
   assign rsp_last_bin      = last_ff;
   assign rsp_flush         = flush_ff;

endmodule

// File: hw/rtl/geometry_residual_binarizer.sv
// top level of the geometry residual binarizer: exp-golomb bins with context tags
// depends on grb_pkg, grb_front and grb_back
//
//   channel   fields                                          handshake
//   request   mode value ctx_select                           push / full
//   result    bin context_kind context_index last_bin flush   empty / pop
//
// one bin per cycle leaves the back end while results are popped; each request is first
// loaded into the sequencer, and the longest 16-bit residual gives 32 bins
// the bin sequencer in grb_back is the limit; the two-entry request queue lets
// requests be taken while the sequencer is busy
// reset is synchronous and empties the queue, the sequencer and the result register
// a stalled result (pop low) holds the sequencer; the queue keeps filling until full
module geometry_residual_binarizer
   import grb_pkg::*;
#(
   parameter int NUM_RES_CONTEXTS = NUM_RES_CONTEXTS_DEF,
   parameter int VALUE_BITS       = VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [1:0]                   req_mode,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic [2:0]                   req_ctx_select,
   // result side
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic                         rsp_bin,
   output logic [2:0]                   rsp_context_kind,
   output logic [2:0]                   rsp_context_index,
   output logic                         rsp_last_bin,
   output logic                         rsp_flush
);

   // classified request between front and back
   logic                  q_valid;
   logic                  q_pop;
   cmd_type               q_cmd;
   logic [VALUE_BITS-1:0] q_sym;

   // front: magnitude, zero test, context clamp, queue
   grb_front #(
      .NUM_RES_CONTEXTS (NUM_RES_CONTEXTS),
      .VALUE_BITS       (VALUE_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_ctx_select (req_ctx_select),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_cmd          (q_cmd),
      .q_sym          (q_sym)
   );

   // back: zero flag, sign, prefix, suffix and termination bins, result register
   grb_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_cmd             (q_cmd),
      .q_sym             (q_sym),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_bin           (rsp_bin),
      .rsp_context_kind  (rsp_context_kind),
      .rsp_context_index (rsp_context_index),
      .rsp_last_bin      (rsp_last_bin),
      .rsp_flush         (rsp_flush)
   );

endmodule

// File: bench/geometry_residual_binarizer_tb.sv
// self-checking bench for geometry_residual_binarizer: directed and random requests,
// bins checked one by one against an in-bench exp-golomb binarizer
// depends on grb_pkg and the geometry_residual_binarizer rtl
`timescale 1ns / 100ps

module geometry_residual_binarizer_tb;
   import grb_pkg::*;

   localparam int VALUE_BITS   = VALUE_BITS_DEF;
   localparam int NUM_CTX      = NUM_RES_CONTEXTS_DEF;
   // exp-golomb orders for run lengths and residual magnitudes
   localparam int RUN_K        = 2;
   localparam int RES_K        = 1;
   localparam int RANDOM_ITEMS = 410;
   // requests left when sender and receiver stop idling
   localparam int TAIL_ITEMS   = 40;
   // cycles to wait after the last bin, covers one full request
   localparam int DRAIN_CYCLES = 48;
   // worst case: about 460 requests of up to 32 bins each, stalls included, stay under it
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic [1:0]            mode;
      logic [VALUE_BITS-1:0] value;
      logic [2:0]            ctx;
   } request_type;

   typedef struct packed {
      logic       decision;
      logic [2:0] kind;
      logic [2:0] index;
      logic       last;
      logic       flush;
   } bin_rec_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_push = 1'b0;
   logic                         req_full;
   logic [1:0]                   req_mode = MODE_RUN;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic [2:0]                   req_ctx_select = '0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic                         rsp_bin;
   logic [2:0]                   rsp_context_kind;
   logic [2:0]                   rsp_context_index;
   logic                         rsp_last_bin;
   logic                         rsp_flush;

   geometry_residual_binarizer dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_ctx_select    (req_ctx_select),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_bin           (rsp_bin),
      .rsp_context_kind  (rsp_context_kind),
      .rsp_context_index (rsp_context_index),
      .rsp_last_bin      (rsp_last_bin),
      .rsp_flush         (rsp_flush)
   );

   // requests waiting to be pushed, and bins waiting to come out
   request_type pending_requests[$];
   bin_rec_type expected_bins[$];
   // bins of the request being binarized
   bin_rec_type item_bins[$];

   int errors        = 0;
   int cycles        = 0;
   int bins_checked  = 0;
   int longest_item  = 0;
   int mode_seen[4]  = '{0, 0, 0, 0};
   bit req_taken     = 1'b0;
   int req_gap       = 0;
   int pop_gap       = 0;
   bit calm_stretch  = 1'b0;

   // -------------------------------------------------------------------------
   // binarizer model
   // -------------------------------------------------------------------------

   // one bin, anything past the 32nd is dropped
   function automatic void emit_bin(input logic d, input logic [2:0] kind,
                                    input logic [2:0] index, input logic flush);
      bin_rec_type rec;
      rec.decision = d;
      rec.kind     = kind;
      rec.index    = index;
      rec.last     = 1'b0;
      rec.flush    = flush;
      if (item_bins.size() < MAX_BINS)
         item_bins.push_back(rec);
   endfunction

   // unary prefix of growing order, a zero, then k suffix bits msb first
   function automatic void emit_expgolomb(input logic [63:0] sym_in, input int k_in,
                                          input logic [2:0] kpre, input logic [2:0] ksuf,
                                          input logic [2:0] index);
      logic [63:0] sym;
      int          k;
      sym = sym_in;
      k   = k_in;
      while (k < 63 && sym >= (64'd1 << k)) begin
         emit_bin(1'b1, kpre, index, 1'b0);
         sym = sym - (64'd1 << k);
         k++;
      end
      emit_bin(1'b0, kpre, index, 1'b0);
      while (k > 0) begin
         k--;
         emit_bin(sym[k], ksuf, index, 1'b0);
      end
   endfunction

   // expected bins of one accepted request, appended in order
   function automatic void binarize_request(input request_type rq);
      logic                  neg;
      logic [VALUE_BITS-1:0] mag_n;
      logic [63:0]           mag;
      logic [2:0]            index;
      bin_rec_type           rec;
      item_bins.delete();
      neg   = rq.value[VALUE_BITS-1];
      // unsigned negate gives the exact magnitude, the most negative value too
      mag_n = neg ? -rq.value : rq.value;
      mag   = 64'(mag_n);
      index = rq.ctx;
      if (int'(rq.ctx) >= NUM_CTX)
         index = 3'(NUM_CTX - 1);
      case (rq.mode)
         MODE_RUN: begin
            // negative run lengths count as zero
            if (neg) mag = '0;
            emit_bin(mag == 0, KIND_LEN_EQ0, 3'd0, 1'b0);
            if (mag != 0)
               emit_expgolomb(mag - 1, RUN_K, KIND_LEN_PREFIX, KIND_LEN_SUFFIX, 3'd0);
         end
         MODE_RES: begin
            emit_bin(mag == 0, KIND_RES_EQ0, index, 1'b0);
            if (mag != 0) begin
               // sign bin is 1 for positive
               emit_bin(!neg, KIND_RES_SIGN, index, 1'b0);
               emit_expgolomb(mag - 1, RES_K, KIND_RES_PREFIX, KIND_RES_SUFFIX, index);
            end
         end
         // only bit 0 of the value matters here
         MODE_TERM: emit_bin(rq.value[0], KIND_FINAL, 3'd0, 1'b1);
         default: ;
      endcase
      for (int i = 0; i < item_bins.size(); i++) begin
         rec = item_bins[i];
         if (i == item_bins.size() - 1)
            rec.last = 1'b1;
         expected_bins.push_back(rec);
      end
      if (item_bins.size() > longest_item)
         longest_item = item_bins.size();
   endfunction

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------

   function automatic void queue_request(input logic [1:0] mode,
                                         input logic [VALUE_BITS-1:0] value,
                                         input logic [2:0] ctx);
      request_type rq;
      rq.mode  = mode;
      rq.value = value;
      rq.ctx   = ctx;
      pending_requests.push_back(rq);
   endfunction

   // mostly short codes so the run stays quick, with full-range and edge values
   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = VALUE_BITS'($urandom_range(0, 24)) - VALUE_BITS'(12);
         5, 6:          v = VALUE_BITS'($urandom_range(0, 600)) - VALUE_BITS'(300);
         7, 8:          v = VALUE_BITS'($urandom);
         default: begin
            case ($urandom_range(0, 5))
               0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
               1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
               2: v = '1;
               3: v = '0;
               4: v = VALUE_BITS'(1);
               default: v = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
            endcase
         end
      endcase
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // clock, reset, timeout
   // -------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // -------------------------------------------------------------------------
   // driver: request side and pop side change on the falling edge
   // -------------------------------------------------------------------------

   always @(negedge clock) begin
      bit       held;
      bit       gaps_on;
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         held = req_push && !req_taken;
         if (req_taken) begin
            pending_requests.delete(0);
            req_taken = 1'b0;
         end
         // random idling, switched off near the end and in calm stretches
         if (cycles % 128 == 0)
            calm_stretch = ($urandom_range(0, 3) == 0);
         gaps_on = (pending_requests.size() > TAIL_ITEMS) && !calm_stretch;

         // request side: a request not yet taken is held as it is
         if (!held) begin
            if (req_gap > 0) begin
               req_gap--;
               req_push <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_push <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
               req_gap = $urandom_range(0, 3);
               req_push <= 1'b0;
            end else begin
               req_mode       <= pending_requests[0].mode;
               req_value      <= pending_requests[0].value;
               req_ctx_select <= pending_requests[0].ctx;
               req_push       <= 1'b1;
            end
         end

         // result side: stall bursts of random length
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            pop_gap = $urandom_range(0, 3);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // monitor: both handshakes sampled on the rising edge
   // -------------------------------------------------------------------------

   always @(posedge clock) begin
      bin_rec_type want;
      request_type rq;
      if (!reset) begin
         cycles++;
         if (rsp_pop && !rsp_empty) begin
            if (expected_bins.size() == 0) begin
               $error("bin out with no request waiting: kind %0d bin %0d",
                      rsp_context_kind, rsp_bin);
               errors++;
            end else begin
               want = expected_bins.pop_front();
               bins_checked++;
               if (rsp_bin !== want.decision) begin
                  $error("rsp_bin: expected %0d, actual %0d", want.decision, rsp_bin);
                  errors++;
               end
               if (rsp_context_kind !== want.kind) begin
                  $error("rsp_context_kind: expected %0d, actual %0d",
                         want.kind, rsp_context_kind);
                  errors++;
               end
               if (rsp_context_index !== want.index) begin
                  $error("rsp_context_index: expected %0d, actual %0d",
                         want.index, rsp_context_index);
                  errors++;
               end
               if (rsp_last_bin !== want.last) begin
                  $error("rsp_last_bin: expected %0d, actual %0d", want.last, rsp_last_bin);
                  errors++;
               end
               if (rsp_flush !== want.flush) begin
                  $error("rsp_flush: expected %0d, actual %0d", want.flush, rsp_flush);
                  errors++;
               end
            end
         end
         // request taken: predict its bins, the driver drops it on the next fall
         if (req_push && !req_full) begin
            rq.mode  = req_mode;
            rq.value = req_value;
            rq.ctx   = req_ctx_select;
            binarize_request(rq);
            mode_seen[req_mode]++;
            req_taken = 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------

   initial begin
      request_type rq;
      int          counted;

      // run lengths: zero, one, negatives clamp to zero, suffix boundaries, max
      queue_request(MODE_RUN, 16'sd0, 3'd5);
      queue_request(MODE_RUN, 16'sd1, 3'd0);
      queue_request(MODE_RUN, -16'sd1, 3'd0);
      queue_request(MODE_RUN, 16'sd4, 3'd0);
      queue_request(MODE_RUN, 16'sd5, 3'd0);
      queue_request(MODE_RUN, 16'sh7fff, 3'd7);
      queue_request(MODE_RUN, 16'sh8000, 3'd0);
      // residuals: zero, signs, small magnitudes, both extremes, every context
      queue_request(MODE_RES, 16'sd0, 3'd0);
      queue_request(MODE_RES, 16'sd1, 3'd1);
      queue_request(MODE_RES, -16'sd1, 3'd2);
      queue_request(MODE_RES, 16'sd2, 3'd3);
      queue_request(MODE_RES, -16'sd3, 3'd4);
      queue_request(MODE_RES, 16'sd6, 3'd5);
      queue_request(MODE_RES, 16'sh7fff, 3'd6);
      // most negative residual, the longest code of 32 bins
      queue_request(MODE_RES, 16'sh8000, 3'd7);
      queue_request(MODE_RES, 16'sh8001, 3'd0);
      // termination: only bit 0 counts
      queue_request(MODE_TERM, 16'sd0, 3'd0);
      queue_request(MODE_TERM, 16'sd1, 3'd3);
      queue_request(MODE_TERM, 16'shfffe, 3'd0);
      queue_request(MODE_TERM, -16'sd1, 3'd7);
      // unused mode makes no bins, before and after a normal request
      queue_request(MODE_NONE, 16'sh5a5a, 3'd2);
      queue_request(MODE_RES, 16'sd7, 3'd1);
      queue_request(MODE_NONE, -16'sd1, 3'd7);

      // random part, unused-mode requests on top of the count
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6:          rq.mode = MODE_RUN;
            7, 8, 9, 10, 11, 12, 13:      rq.mode = MODE_RES;
            14:                           rq.mode = MODE_TERM;
            default:                      rq.mode = MODE_NONE;
         endcase
         rq.value = (rq.mode == MODE_TERM) ? VALUE_BITS'($urandom) : random_value();
         rq.ctx   = 3'($urandom_range(0, 7));
         pending_requests.push_back(rq);
         if (rq.mode != MODE_NONE)
            counted++;
      end

      @(negedge reset);
      while (pending_requests.size() != 0 || expected_bins.size() != 0)
         @(posedge clock);
      // catch stray bins after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bins.size() != 0) begin
         $error("%0d bins never came out", expected_bins.size());
         errors++;
      end

      $display("covered %0d run, %0d residual, %0d termination and %0d unused-mode requests",
               mode_seen[MODE_RUN], mode_seen[MODE_RES], mode_seen[MODE_TERM],
               mode_seen[MODE_NONE]);
      $display("checked %0d bins, longest request %0d bins, %0d cycles",
               bins_checked, longest_item, cycles);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/grb_pkg.sv
hw/rtl/grb_front.sv
hw/rtl/grb_back.sv
hw/rtl/geometry_residual_binarizer.sv
bench/geometry_residual_binarizer_tb.sv
